/* design/wpm_pkg.sv */
// wpm_pkg: shared types and constants of the wildcard pattern matcher
// no dependencies; used by the register file, the step logic and the top level
package wpm_pkg;

	localparam int ADDR_W     = 6;
	localparam int DATA_W     = 64;
	localparam int SLOT_CHARS = 32;
	localparam int LEN_W      = 6;

	localparam logic [7:0] WILD_ONE = 8'h3F;
	localparam logic [7:0] WILD_RUN = 8'h2A;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	typedef enum logic [2:0] {
		REG_LENGTH  = 3'd0,
		REG_BYTES_0 = 3'd1,
		REG_BYTES_1 = 3'd2,
		REG_BYTES_2 = 3'd3,
		REG_BYTES_3 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0]                 length;
		logic [SLOT_CHARS-1:0][7:0]       chars;
	} pattern_cfg_t;

endpackage

/* design/wpm_subject_if.sv */
// wpm_subject_if: input channel of the matcher, at most one subject character per item
// no dependencies
interface wpm_subject_if #(
	parameter int CHAR_BITS = 8
) ();
	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] char_code;
	logic                 has_char;
	logic                 last;

	modport source (output valid, char_code, has_char, last, input ready);
	modport sink   (input valid, char_code, has_char, last, output ready);
endinterface

/* design/wpm_result_if.sv */
// wpm_result_if: result channel of the matcher, one item per ended string
// no dependencies
interface wpm_result_if ();
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink   (input valid, matched, output ready);
endinterface

/* design/wildcard_pattern_matcher_core.sv */
// wildcard_pattern_matcher_core: top level, input stage, position set and result register
// depends on wpm_pkg, wpm_subject_if, wpm_result_if, wpm_regs, wpm_step
//
//   channel   direction  payload                         handshake
//   subject   in         char_code, has_char, last       valid / ready
//   result    out        matched                         valid / ready
//   apb       in         pattern_length, pattern_bytes   psel / penable / pwrite
//
// one item per cycle unless a stalled result holds back an ending item
// the next position set is formed combinationally through the star-run closure adder
// reset clears the pattern, the position set and both valid flags
// a stalled result holds back only an item that ends a string
module wildcard_pattern_matcher_core #(
	parameter int PATTERN_MAX = 32,
	parameter int CHAR_BITS   = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [wpm_pkg::ADDR_W-1:0] paddr,
	input  logic [wpm_pkg::DATA_W-1:0] pwdata,
	output logic [wpm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	wpm_subject_if.sink                subject,
	wpm_result_if.source               result
);
	import wpm_pkg::*;

	pattern_cfg_t         cfg;
	logic                 valid_s1;
	logic [CHAR_BITS-1:0] char_s1;
	logic                 has_s1;
	logic                 last_s1;
	logic                 adv_s1;
	logic [PATTERN_MAX:0] state_q;
	logic                 open_q;
	logic [PATTERN_MAX:0] next_state;
	logic                 step_match;
	logic                 res_valid_q;
	logic                 matched_q;

	wpm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wpm_step #(
		.PATTERN_MAX (PATTERN_MAX),
		.CHAR_BITS   (CHAR_BITS)
	) u_step (
		.cfg        (cfg),
		.state      (state_q),
		.open       (open_q),
		.char_code  (char_s1),
		.has_char   (has_s1),
		.next_state (next_state),
		.matched    (step_match)
	);

	assign adv_s1        = valid_s1 && !(last_s1 && res_valid_q && !result.ready);
	assign subject.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (subject.valid && subject.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (subject.valid && subject.ready) begin
			char_s1 <= subject.char_code;
			has_s1  <= subject.has_char;
			last_s1 <= subject.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			open_q  <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			state_q <= '0;
			open_q  <= 1'b0;
		end else if (adv_s1 && has_s1) begin
			state_q <= next_state;
			open_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			matched_q <= step_match;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.matched = matched_q;

endmodule

/* design/wpm_regs.sv */
// wpm_regs: apb register file holding the pattern length and pattern bytes
// depends on wpm_pkg
module wpm_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [wpm_pkg::ADDR_W-1:0] paddr,
	input  logic [wpm_pkg::DATA_W-1:0] pwdata,
	output logic [wpm_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output wpm_pkg::pattern_cfg_t     cfg
);
	import wpm_pkg::*;

	logic [LEN_W-1:0]      length_q;
	logic [3:0][DATA_W-1:0] words_q;
	logic                  wr_en;
	reg_idx_t              idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			words_q  <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_LENGTH:  length_q   <= pwdata[LEN_W-1:0];
				REG_BYTES_0: words_q[0] <= pwdata;
				REG_BYTES_1: words_q[1] <= pwdata;
				REG_BYTES_2: words_q[2] <= pwdata;
				REG_BYTES_3: words_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LENGTH:  prdata = {{(DATA_W-LEN_W){1'b0}}, length_q};
			REG_BYTES_0: prdata = words_q[0];
			REG_BYTES_1: prdata = words_q[1];
			REG_BYTES_2: prdata = words_q[2];
			REG_BYTES_3: prdata = words_q[3];
			default:     prdata = '0;
		endcase
	end

	assign cfg.length = length_q;
	assign cfg.chars  = words_q;

endmodule

/* design/wpm_step.sv */
// wpm_step: next set of reachable pattern positions for one character
// depends on wpm_pkg
module wpm_step #(
	parameter int PATTERN_MAX = 32,
	parameter int CHAR_BITS   = 8
) (
	input  wpm_pkg::pattern_cfg_t   cfg,
	input  logic [PATTERN_MAX:0]    state,
	input  logic                    open,
	input  logic [CHAR_BITS-1:0]    char_code,
	input  logic                    has_char,
	output logic [PATTERN_MAX:0]    next_state,
	output logic                    matched
);
	import wpm_pkg::*;

	localparam int N = PATTERN_MAX + 1;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(PATTERN_MAX);

	logic [N-1:0][7:0] pchar;
	logic [LEN_W-1:0]  len;
	logic [N-1:0]      keep;
	logic [N-1:0]      at_len;
	logic [N-1:0]      is_star;
	logic [N-1:0]      hit;
	logic [N-1:0]      cur;
	logic [N-1:0]      moved;

	// a set bit at a star spreads to the end of its run of stars and one past it
	function automatic logic [N-1:0] close_run(input logic [N-1:0] s,
			input logic [N-1:0] star, input logic [N-1:0] msk);
		logic [N-1:0] x;
		x = s & star;
		return (s | ((x + star) ^ star)) & msk;
	endfunction

	for (genvar g = 0; g < N; g++) begin : g_pchar
		if (g < SLOT_CHARS) begin : g_stored
			assign pchar[g] = cfg.chars[g];
		end else begin : g_blank
			assign pchar[g] = 8'h00;
		end
	end

	assign len = (cfg.length > LEN_CAP) ? LEN_CAP : cfg.length;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			keep[i]    = LEN_W'(i) <= len;
			at_len[i]  = LEN_W'(i) == len;
			is_star[i] = (LEN_W'(i) < len) && (pchar[i] == WILD_RUN);
			if (pchar[i] == WILD_ONE) begin
				hit[i] = char_code != CHAR_BITS'(DOT_CHAR);
			end else begin
				hit[i] = char_code == CHAR_BITS'(pchar[i]);
			end
			hit[i] = hit[i] && (LEN_W'(i) < len) && !is_star[i];
		end
		cur   = (open ? state : close_run(N'(1), is_star, keep)) & keep;
		moved = (cur & is_star) | ((cur & hit) << 1);
		next_state = has_char ? close_run(moved, is_star, keep) : cur;
		matched    = |(next_state & at_len);
	end

endmodule

/* verif/wildcard_pattern_matcher_core_tb.sv */
`timescale 1ns / 1ps
// wildcard_pattern_matcher_core_tb: drives subject strings against wildcard patterns
// set over apb and checks each match verdict against a position-set predictor
// depends on wpm_pkg, wpm_subject_if, wpm_result_if and wildcard_pattern_matcher_core
module wildcard_pattern_matcher_core_tb;
	import wpm_pkg::*;

	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       last;
	} subj_item_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	wpm_subject_if #(.CHAR_BITS(8)) subject_ch ();
	wpm_result_if                   result_ch ();

	wildcard_pattern_matcher_core #(
		.PATTERN_MAX(32),
		.CHAR_BITS  (8)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.subject(subject_ch),
		.result (result_ch)
	);

	always #6 clk = ~clk;

	// pattern copy and position set of the predictor
	logic [5:0]  cfg_len;
	logic [7:0]  cfg_chars [SLOT_CHARS];
	logic [32:0] active_set;
	logic        string_live;

	subj_item_t  subject_backlog [$];
	logic        pending_verdicts [$];
	logic [7:0]  subj_chars [$];
	logic [7:0]  new_chars [SLOT_CHARS];

	int  items_pushed;
	int  items_taken;
	int  err_count;
	int  gap_left;
	int  stall_left;
	int  hold_left;
	bit  calm;
	bit  hold_req;
	bit  hold_done;

	function automatic logic [32:0] reach_mask(input logic [5:0] n);
		return (33'd1 << (n + 1)) - 33'd1;
	endfunction

	function automatic logic [32:0] star_closure(input logic [32:0] set, input logic [5:0] n);
		logic [32:0] s;
		s = set;
		for (int i = 0; i < SLOT_CHARS; i++) begin
			if (i < n && s[i] && cfg_chars[i] == WILD_RUN)
				s[i+1] = 1'b1;
		end
		return s & reach_mask(n);
	endfunction

	function automatic logic [32:0] consume_char(input logic [32:0] set, input logic [7:0] c,
			input logic [5:0] n);
		logic [32:0] nxt;
		logic [7:0]  p;
		nxt = '0;
		for (int i = 0; i < SLOT_CHARS; i++) begin
			if (i < n && set[i]) begin
				p = cfg_chars[i];
				if (p == WILD_RUN)
					nxt[i] = 1'b1;
				else if ((p == WILD_ONE) ? (c != DOT_CHAR) : (p == c))
					nxt[i+1] = 1'b1;
			end
		end
		return star_closure(nxt, n);
	endfunction

	task automatic take_item(input subj_item_t it);
		logic [5:0] n;
		n = (cfg_len > 6'd32) ? 6'd32 : cfg_len;
		if (!it.has_char && !it.last)
			return;
		if (!string_live) begin
			active_set  = star_closure(33'd1, n);
			string_live = 1'b1;
		end
		active_set &= reach_mask(n);
		if (it.has_char)
			active_set = consume_char(active_set, it.char_code, n);
		if (it.last) begin
			pending_verdicts.insert(pending_verdicts.size(), active_set[n]);
			active_set  = '0;
			string_live = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// item driver
	always @(posedge clk) begin : feed_subject
		subj_item_t nxt;
		if (!arst_n) begin
			subject_ch.valid <= 1'b0;
		end else if (!subject_ch.valid || subject_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				subject_ch.valid <= 1'b0;
			end else if (subject_backlog.size() > 0) begin
				nxt = subject_backlog.pop_front();
				subject_ch.valid     <= 1'b1;
				subject_ch.char_code <= nxt.char_code;
				subject_ch.has_char  <= nxt.has_char;
				subject_ch.last      <= nxt.last;
				if (!calm && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 6);
			end else begin
				subject_ch.valid <= 1'b0;
			end
		end
	end

	// accepted items into the predictor
	always @(posedge clk) begin
		if (arst_n && subject_ch.valid && subject_ch.ready) begin
			take_item('{subject_ch.char_code, subject_ch.has_char, subject_ch.last});
			items_taken++;
		end
	end

	// result sink: random stalls and one long hold-off
	always @(posedge clk) begin : sink_ready
		logic rdy;
		rdy = 1'b1;
		if (!arst_n) begin
			rdy = 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 300;
			rdy = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			rdy = 1'b0;
		end
		result_ch.ready <= rdy;
	end

	// result checker
	always @(posedge clk) begin : check_result
		logic want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected result matched=%0b", result_ch.matched));
			end else begin
				want = pending_verdicts.pop_front();
				if (result_ch.matched !== want)
					report_mismatch($sformatf("matched=%0b, wanted %0b", result_ch.matched, want));
			end
		end
	end

	task automatic apb_write(input reg_idx_t r, input logic [63:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
			REG_LENGTH: cfg_len = v[5:0];
			REG_BYTES_0, REG_BYTES_1, REG_BYTES_2, REG_BYTES_3: begin
				for (int j = 0; j < 8; j++)
					cfg_chars[(int'(r) - 1) * 8 + j] = v[j*8 +: 8];
			end
			default: ;
		endcase
	endtask

	task automatic set_pattern(input logic [5:0] len);
		logic [63:0] w;
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 8; j++)
				w[j*8 +: 8] = new_chars[k*8 + j];
			apb_write(reg_idx_t'(k + 1), w);
		end
		apb_write(REG_LENGTH, {58'd0, len});
	endtask

	// wait until every item is taken and every verdict is back, then a latency pause
	task automatic settle();
		do
			@(negedge clk);
		while (items_taken != items_pushed || pending_verdicts.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic push_item(input logic [7:0] c, input logic h, input logic l);
		subject_backlog.insert(subject_backlog.size(), '{c, h, l});
		items_pushed++;
	endtask

	task automatic push_string(input bit sep_end, input bit idles);
		for (int i = 0; i < subj_chars.size(); i++) begin
			if (idles && $urandom_range(0, 9) == 0)
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_item(subj_chars[i], 1'b1, !sep_end && i == subj_chars.size() - 1);
		end
		if (sep_end || subj_chars.size() == 0)
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return "a";
			3, 4:    return "b";
			5:       return DOT_CHAR;
			6:       return 8'h00;
			7:       return ($urandom_range(0, 1) != 0) ? WILD_ONE : WILD_RUN;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_pattern_char();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4: return "a";
			5, 6, 7:       return "b";
			8, 9, 10, 11:  return WILD_RUN;
			12, 13, 14:    return WILD_ONE;
			15, 16:        return DOT_CHAR;
			17:            return 8'h00;
			default:       return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// subject drawn to fit the pattern, then sometimes broken
	task automatic build_fitting_subject();
		int n;
		logic [7:0] c;
		n = (cfg_len > 6'd32) ? 32 : int'(cfg_len);
		subj_chars.delete();
		for (int i = 0; i < n; i++) begin
			if (cfg_chars[i] == WILD_RUN) begin
				repeat ($urandom_range(0, 3)) subj_chars.insert(subj_chars.size(), pick_char());
			end else if (cfg_chars[i] == WILD_ONE) begin
				do
					c = pick_char();
				while (c == DOT_CHAR);
				subj_chars.insert(subj_chars.size(), c);
			end else begin
				subj_chars.insert(subj_chars.size(), cfg_chars[i]);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 2))
				0: if (subj_chars.size() > 0)
					subj_chars[$urandom_range(0, subj_chars.size() - 1)] = pick_char();
				1: if (subj_chars.size() > 0)
					subj_chars.delete($urandom_range(0, subj_chars.size() - 1));
				default: subj_chars.insert($urandom_range(0, subj_chars.size()), pick_char());
			endcase
		end
	endtask

	task automatic run_random_phase(input int target, input int len_choice);
		int  phase_start;
		int  n;
		logic [5:0] len;
		case (len_choice)
			0: len = 6'($urandom_range(1, 8));
			1: len = 6'($urandom_range(9, 32));
			2: len = 6'($urandom_range(33, 63));
			3: len = 6'd0;
			default: len = 6'd32;
		endcase
		for (int i = 0; i < SLOT_CHARS; i++)
			new_chars[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: pick_pattern_char();
		set_pattern(len);
		phase_start = items_pushed;
		while (items_pushed - phase_start < target) begin
			case ($urandom_range(0, 19))
				14, 15, 16, 17: begin
					subj_chars.delete();
					n = $urandom_range(0, ((len > 6'd32) ? 32 : int'(len)) + 3);
					if (n > 12)
						n = $urandom_range(0, 12);
					repeat (n) subj_chars.insert(subj_chars.size(), pick_char());
				end
				18, 19: subj_chars.delete();
				default: build_fitting_subject();
			endcase
			push_string($urandom_range(0, 4) == 0, 1'b1);
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		subject_ch.valid     = 1'b0;
		subject_ch.char_code = '0;
		subject_ch.has_char  = 1'b0;
		subject_ch.last      = 1'b0;
		result_ch.ready      = 1'b0;
		cfg_len              = '0;
		for (int i = 0; i < SLOT_CHARS; i++)
			cfg_chars[i] = 8'h00;
		active_set   = '0;
		string_live  = 1'b0;
		items_pushed = 0;
		items_taken  = 0;
		err_count    = 0;
		gap_left     = 0;
		stall_left   = 0;
		hold_left    = 0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		hold_done    = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset pattern is empty: empty string, a one-character string, an idle item
		push_item(8'h5A, 1'b0, 1'b1);
		push_item("a", 1'b1, 1'b1);
		push_item(8'hA5, 1'b0, 1'b0);
		settle();

		// literal, single wildcard, star, zero byte and dot
		for (int i = 0; i < SLOT_CHARS; i++)
			new_chars[i] = 8'h00;
		new_chars[0] = "a";
		new_chars[1] = WILD_ONE;
		new_chars[2] = WILD_RUN;
		new_chars[3] = 8'h00;
		new_chars[4] = DOT_CHAR;
		set_pattern(6'd5);
		subj_chars = '{"a", "b", 8'h00, DOT_CHAR};
		push_string(1'b0, 1'b0);
		subj_chars = '{"a", DOT_CHAR, 8'h00, DOT_CHAR};
		push_string(1'b0, 1'b0);
		push_item(8'hFF, 1'b0, 1'b0);
		subj_chars = '{"a", "b", "x", "y", 8'h00, DOT_CHAR};
		push_string(1'b1, 1'b0);
		settle();

		// over-long length, all stars
		for (int i = 0; i < SLOT_CHARS; i++)
			new_chars[i] = WILD_RUN;
		set_pattern(6'd63);
		push_item(8'h00, 1'b0, 1'b1);
		push_item("x", 1'b1, 1'b1);
		settle();

		// empty pattern over all-ones bytes
		for (int i = 0; i < SLOT_CHARS; i++)
			new_chars[i] = 8'hFF;
		set_pattern(6'd0);
		push_item(8'h00, 1'b0, 1'b1);
		push_item(8'hFF, 1'b1, 1'b1);
		settle();

		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 1)
				hold_req = 1'b1;
			if (ph == 11)
				calm = 1'b1;
			case (ph)
				1:  run_random_phase(65, 0);
				3:  run_random_phase(65, 4);
				5:  run_random_phase(65, 2);
				7:  run_random_phase(65, 3);
				default: run_random_phase(65, ($urandom_range(0, 4) == 0) ? 1 : 0);
			endcase
			settle();
		end

		repeat (10) @(negedge clk);
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
